/* rtl/dual_timer_counter_four_modes_unit_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the dual timer/counter unit
// Shared wrappers around concurrent assertions used by the port checker.
// ---------------------------------------------------------------------------
`ifndef DUAL_TIMER_COUNTER_FOUR_MODES_UNIT_ASSERT_SVH
`define DUAL_TIMER_COUNTER_FOUR_MODES_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define DTC_ASSERT_IMPLY(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("dtc assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define DTC_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("dtc assertion failed");

`endif

/* rtl/dtc_pkg.sv */
// ---------------------------------------------------------------------------
// Dual timer/counter package
// Types and codes shared by the timer/counter modules.
// ---------------------------------------------------------------------------
package dtc_pkg;

    // Item operation codes.
    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_WR_COUNT = 2'd1;
    localparam logic [1:0] OP_WR_CTRL  = 2'd2;

    // Count byte select codes for a count write.
    localparam logic [1:0] SEL_LOW0  = 2'd0;
    localparam logic [1:0] SEL_HIGH0 = 2'd1;
    localparam logic [1:0] SEL_LOW1  = 2'd2;
    localparam logic [1:0] SEL_HIGH1 = 2'd3;

    // Timer modes.
    localparam logic [1:0] MODE_13BIT  = 2'd0;
    localparam logic [1:0] MODE_16BIT  = 2'd1;
    localparam logic [1:0] MODE_RELOAD = 2'd2;
    localparam logic [1:0] MODE_SPLIT  = 2'd3;

    // Bit positions in the control write data.
    localparam int unsigned CTRL_RUN0  = 4;
    localparam int unsigned CTRL_FLAG0 = 5;
    localparam int unsigned CTRL_RUN1  = 6;
    localparam int unsigned CTRL_FLAG1 = 7;

    localparam logic [7:0] BYTE_MAX = 8'hff;
    localparam logic [4:0] PRESCALE_MAX = 5'h1f;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] reg_sel;
        logic [7:0] wr_data;
        logic       t0_fall;
        logic       t1_fall;
        logic       int0_level;
        logic       int1_level;
    } t_item;

    typedef struct packed {
        logic [7:0] low0;
        logic [7:0] high0;
        logic [7:0] low1;
        logic [7:0] high1;
        logic       flag0;
        logic       flag1;
    } t_result;

    typedef struct packed {
        logic [7:0] hi;
        logic [7:0] lo;
    } t_count;

endpackage

/* rtl/dual_timer_counter_four_modes_unit.sv */
// ---------------------------------------------------------------------------
// Dual timer/counter unit, modes 0 to 3
// Two classic 8-bit MCU timer/counters, one item per clock while not stalled.
// ---------------------------------------------------------------------------
// Usage:
// The input channel carries one item per handshake: a machine-cycle tick with
// the pin edge and interrupt level samples, a count byte write, or a write of
// the run and flag bits. An item is taken at a rising edge with i_valid high
// and o_stall low. Every item yields exactly one result item on the output
// channel: the four count bytes and both overflow flags after that item.
// A result is taken at a rising edge with o_valid high and i_stall low.
// The item first lands in an input register; once the result register is free
// to load, the timer update logic applies it to the timer state and loads the
// result register. A result thus passes through both registers, and one item
// per cycle is sustained as long as the receiver keeps taking results.
// While the receiver stalls, the result register holds its item, the input
// register fills up behind it and only then is o_stall raised upstream.
// The mode register is written through the configuration channel, which is
// always ready; it must only change while no item is in flight.
// A synchronous active-low reset clears the timer state, the mode register
// and both valid bits; nothing is in flight afterwards.
// ---------------------------------------------------------------------------
module dual_timer_counter_four_modes_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Item input channel.
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_op,
    input  logic [1:0] i_reg_sel,
    input  logic [7:0] i_wr_data,
    input  logic       i_t0_fall,
    input  logic       i_t1_fall,
    input  logic       i_int0_level,
    input  logic       i_int1_level,
    // Result output channel.
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_low0_out,
    output logic [7:0] o_high0_out,
    output logic [7:0] o_low1_out,
    output logic [7:0] o_high1_out,
    output logic       o_flag0_out,
    output logic       o_flag1_out,
    // Mode register write channel.
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);
    import dtc_pkg::*;

    logic       r_in_valid;
    t_item      r_in;
    logic       r_out_valid;
    t_result    r_out;
    logic [7:0] r_timer_mode;

    logic       out_free;
    logic       in_free;
    logic       upd_en;
    t_result    upd_result;

    // The result register can load when it is empty or being taken this cycle.
    assign out_free = !r_out_valid || !i_stall;
    assign upd_en   = r_in_valid && out_free;
    // The input register can load when empty or when it moves on this cycle.
    assign in_free  = !r_in_valid || out_free;

    assign o_stall     = !in_free;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_timer_mode <= '0;
        end else begin
            if (in_free) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (i_cfg_valid) begin
                r_timer_mode <= i_cfg_data;
            end
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_valid && in_free) begin
            r_in <= '{op: i_op, reg_sel: i_reg_sel, wr_data: i_wr_data,
                      t0_fall: i_t0_fall, t1_fall: i_t1_fall,
                      int0_level: i_int0_level, int1_level: i_int1_level};
        end
        if (upd_en) begin
            r_out <= upd_result;
        end
    end

    dtc_update u_update (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (upd_en),
        .i_item       (r_in),
        .i_timer_mode (r_timer_mode),
        .o_result     (upd_result)
    );

    assign o_valid     = r_out_valid;
    assign o_low0_out  = r_out.low0;
    assign o_high0_out = r_out.high0;
    assign o_low1_out  = r_out.low1;
    assign o_high1_out = r_out.high1;
    assign o_flag0_out = r_out.flag0;
    assign o_flag1_out = r_out.flag1;

endmodule

/* rtl/dtc_advance.sv */
// ---------------------------------------------------------------------------
// Timer count step
// Advances one timer's count bytes by one count in the selected mode.
// ---------------------------------------------------------------------------
module dtc_advance (
    input  logic            i_en,
    input  logic [1:0]      i_mode,
    input  dtc_pkg::t_count i_cnt,
    output dtc_pkg::t_count o_cnt,
    output logic            o_ovf
);
    import dtc_pkg::*;

    logic [4:0] lo5_inc;
    logic [7:0] lo_inc;
    logic [7:0] hi_inc;

    assign lo5_inc = i_cnt.lo[4:0] + 5'd1;
    assign lo_inc  = i_cnt.lo + 8'd1;
    assign hi_inc  = i_cnt.hi + 8'd1;

    always_comb begin
        o_cnt = i_cnt;
        o_ovf = 1'b0;
        if (i_en) begin
            case (i_mode)
                MODE_13BIT: begin
                    // The upper three bits of the low byte are cleared on every step.
                    o_cnt.lo = {3'b000, lo5_inc};
                    if (i_cnt.lo[4:0] == PRESCALE_MAX) begin
                        o_cnt.hi = hi_inc;
                        o_ovf    = (i_cnt.hi == BYTE_MAX);
                    end
                end
                MODE_16BIT: begin
                    o_cnt.lo = lo_inc;
                    if (i_cnt.lo == BYTE_MAX) begin
                        o_cnt.hi = hi_inc;
                        o_ovf    = (i_cnt.hi == BYTE_MAX);
                    end
                end
                MODE_RELOAD: begin
                    if (i_cnt.lo == BYTE_MAX) begin
                        o_cnt.lo = i_cnt.hi;
                        o_ovf    = 1'b1;
                    end else begin
                        o_cnt.lo = lo_inc;
                    end
                end
                default: begin
                    o_cnt.lo = lo_inc;
                    o_ovf    = (i_cnt.lo == BYTE_MAX);
                end
            endcase
        end
    end

endmodule

/* rtl/dtc_update.sv */
// ---------------------------------------------------------------------------
// Timer state and item update
// Holds count bytes, run bits and flags, applying one item per cycle when enabled.
// ---------------------------------------------------------------------------
module dtc_update (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  dtc_pkg::t_item   i_item,
    input  logic [7:0]       i_timer_mode,
    output dtc_pkg::t_result o_result
);
    import dtc_pkg::*;

    logic [7:0] r_low0, r_high0, r_low1, r_high1;
    logic       r_flag0, r_flag1, r_run0, r_run1;
    logic [7:0] n_low0, n_high0, n_low1, n_high1;
    logic       n_flag0, n_flag1, n_run0, n_run1;

    logic [1:0] mode0, mode1;
    logic       split0;
    logic       en0, en1;
    t_count     cnt0_in, cnt1_in, cnt0_out, cnt1_out;
    logic       ovf0, ovf1;
    logic       split_hi_step;

    assign mode0  = i_timer_mode[1:0];
    assign mode1  = i_timer_mode[5:4];
    assign split0 = (mode0 == MODE_SPLIT);

    // Run condition: run bit, gate by interrupt pin, event (cycle or pin edge).
    assign en0 = r_run0 && (!i_timer_mode[3] || i_item.int0_level)
              && (!i_timer_mode[2] || i_item.t0_fall);
    // Timer 1 ignores its run bit while timer 0 is split, and holds in split mode.
    assign en1 = (mode1 != MODE_SPLIT) && (split0 || r_run1)
              && (!i_timer_mode[7] || i_item.int1_level)
              && (!i_timer_mode[6] || i_item.t1_fall);

    assign cnt0_in = '{hi: r_high0, lo: r_low0};
    assign cnt1_in = '{hi: r_high1, lo: r_low1};

    dtc_advance u_adv0 (
        .i_en   (en0),
        .i_mode (mode0),
        .i_cnt  (cnt0_in),
        .o_cnt  (cnt0_out),
        .o_ovf  (ovf0)
    );

    dtc_advance u_adv1 (
        .i_en   (en1),
        .i_mode (mode1),
        .i_cnt  (cnt1_in),
        .o_cnt  (cnt1_out),
        .o_ovf  (ovf1)
    );

    // In split mode the high byte of timer 0 is an 8-bit timer run by run1.
    assign split_hi_step = split0 && r_run1;

    always_comb begin
        n_low0  = r_low0;
        n_high0 = r_high0;
        n_low1  = r_low1;
        n_high1 = r_high1;
        n_flag0 = r_flag0;
        n_flag1 = r_flag1;
        n_run0  = r_run0;
        n_run1  = r_run1;
        case (i_item.op)
            OP_TICK: begin
                n_low0  = cnt0_out.lo;
                n_high0 = split_hi_step ? (cnt0_out.hi + 8'd1) : cnt0_out.hi;
                n_low1  = cnt1_out.lo;
                n_high1 = cnt1_out.hi;
                n_flag0 = r_flag0 | ovf0;
                if (split0) begin
                    n_flag1 = r_flag1 | (split_hi_step && (r_high0 == BYTE_MAX));
                end else begin
                    n_flag1 = r_flag1 | ovf1;
                end
            end
            OP_WR_COUNT: begin
                case (i_item.reg_sel)
                    SEL_LOW0:  n_low0  = i_item.wr_data;
                    SEL_HIGH0: n_high0 = i_item.wr_data;
                    SEL_LOW1:  n_low1  = i_item.wr_data;
                    default:   n_high1 = i_item.wr_data;
                endcase
            end
            OP_WR_CTRL: begin
                n_run0  = i_item.wr_data[CTRL_RUN0];
                n_flag0 = i_item.wr_data[CTRL_FLAG0];
                n_run1  = i_item.wr_data[CTRL_RUN1];
                n_flag1 = i_item.wr_data[CTRL_FLAG1];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low0  <= '0;
            r_high0 <= '0;
            r_low1  <= '0;
            r_high1 <= '0;
            r_flag0 <= 1'b0;
            r_flag1 <= 1'b0;
            r_run0  <= 1'b0;
            r_run1  <= 1'b0;
        end else if (i_en) begin
            r_low0  <= n_low0;
            r_high0 <= n_high0;
            r_low1  <= n_low1;
            r_high1 <= n_high1;
            r_flag0 <= n_flag0;
            r_flag1 <= n_flag1;
            r_run0  <= n_run0;
            r_run1  <= n_run1;
        end
    end

    assign o_result = '{low0: n_low0, high0: n_high0, low1: n_low1, high1: n_high1,
                        flag0: n_flag0, flag1: n_flag1};

endmodule

/* rtl/dtc_checker.sv */
// ---------------------------------------------------------------------------
// Dual timer/counter port checker
// Watches the top-level ports and flags handshake and flow-control slips.
// ---------------------------------------------------------------------------
`include "dual_timer_counter_four_modes_unit_assert.svh"

module dtc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [1:0] i_op,
    input logic [1:0] i_reg_sel,
    input logic [7:0] i_wr_data,
    input logic       i_t0_fall,
    input logic       i_t1_fall,
    input logic       i_int0_level,
    input logic       i_int1_level,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_low0_out,
    input logic [7:0] o_high0_out,
    input logic [7:0] o_low1_out,
    input logic [7:0] o_high1_out,
    input logic       o_flag0_out,
    input logic       o_flag1_out
);

    logic [15:0] in_bits;
    logic [33:0] res_bits;

    assign in_bits  = {i_op, i_reg_sel, i_wr_data, i_t0_fall, i_t1_fall,
                       i_int0_level, i_int1_level};
    assign res_bits = {o_low0_out, o_high0_out, o_low1_out, o_high1_out,
                       o_flag0_out, o_flag1_out};

    // Backpressure upstream only arises from a held result downstream.
    `DTC_ASSERT_IMPLY(a_stall_only_when_full, i_clk, !i_rst_n, o_stall, o_valid && i_stall)

    // Reset leaves nothing in flight.
    `DTC_ASSERT_NEXT(a_reset_empties, i_clk, 1'b0, !i_rst_n, !o_valid && !o_stall)

    // A stalled result stays valid and unchanged.
    `DTC_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_valid && i_stall, o_valid && $stable(res_bits))

    // A stalled input item stays offered and unchanged.
    `DTC_ASSERT_NEXT(a_in_hold, i_clk, !i_rst_n, i_valid && o_stall, i_valid && $stable(in_bits))

endmodule

bind dual_timer_counter_four_modes_unit dtc_checker u_dtc_checker (.*);

/* tb/sv/dtc_count_checker.sv */
// ---------------------------------------------------------------------------
// Count checker for the dual timer/counter unit
// Watches the item, result and mode channels, predicts the count bytes and
// overflow flags after every accepted item and compares each result with them.
// ---------------------------------------------------------------------------
module dtc_count_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_item_valid,
    input  logic       i_item_stall,
    input  logic [1:0] i_op,
    input  logic [1:0] i_reg_sel,
    input  logic [7:0] i_wr_data,
    input  logic       i_t0_fall,
    input  logic       i_t1_fall,
    input  logic       i_int0_level,
    input  logic       i_int1_level,
    input  logic       i_res_valid,
    input  logic       i_res_stall,
    input  logic [7:0] i_low0,
    input  logic [7:0] i_high0,
    input  logic [7:0] i_low1,
    input  logic [7:0] i_high1,
    input  logic       i_flag0,
    input  logic       i_flag1,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [7:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);
    import dtc_pkg::*;

    typedef struct packed {
        t_count cnt;
        logic   wrap;
    } t_advance;

    // Shadow copy of the timer state and the mode register.
    t_count     timer0;
    t_count     timer1;
    logic       ovf0;
    logic       ovf1;
    logic       run0;
    logic       run1;
    logic [7:0] mode_q;

    t_result    count_snapshots_q[$];
    t_result    want;
    t_item      item;
    int         fails = 0;

    assign o_fail_count = fails;

    // One count step of a timer in the given mode; wrap flags an overflow.
    function automatic t_advance count_once(input t_count c, input logic [1:0] m);
        t_advance s;
        s.cnt  = c;
        s.wrap = 1'b0;
        case (m)
            MODE_13BIT: begin
                s.cnt.lo = {3'b000, c.lo[4:0] + 5'd1};
                if (c.lo[4:0] == PRESCALE_MAX) begin
                    s.cnt.hi = c.hi + 8'd1;
                    s.wrap   = (c.hi == BYTE_MAX);
                end
            end
            MODE_16BIT: begin
                s.cnt  = c + 16'd1;
                s.wrap = (c == {BYTE_MAX, BYTE_MAX});
            end
            MODE_RELOAD: begin
                s.wrap   = (c.lo == BYTE_MAX);
                s.cnt.lo = s.wrap ? c.hi : c.lo + 8'd1;
            end
            default: begin
                s.cnt.lo = c.lo + 8'd1;
                s.wrap   = (c.lo == BYTE_MAX);
            end
        endcase
        return s;
    endfunction

    // Applies one item to the shadow state and returns the counts after it.
    function automatic t_result next_counts(input t_item it);
        t_result  r;
        t_advance a;
        logic     en0;
        logic     en1;
        // Low nibble: timer 0; high nibble: timer 1 (mode, counter select, gate).
        en0 = (!mode_q[2] || it.t0_fall) && (!mode_q[3] || it.int0_level);
        en1 = (!mode_q[6] || it.t1_fall) && (!mode_q[7] || it.int1_level);
        case (it.op)
            OP_TICK: begin
                if (run0 && en0) begin
                    a = count_once(timer0, mode_q[1:0]);
                    timer0 = a.cnt;
                    if (a.wrap) ovf0 = 1'b1;
                end
                if (mode_q[1:0] == MODE_SPLIT) begin
                    // High byte of timer 0 borrows run1 and flag 1.
                    if (run1) begin
                        timer0.hi = timer0.hi + 8'd1;
                        if (timer0.hi == 8'd0) ovf1 = 1'b1;
                    end
                    if (mode_q[5:4] != MODE_SPLIT && en1) begin
                        a = count_once(timer1, mode_q[5:4]);
                        timer1 = a.cnt;
                    end
                end else if (mode_q[5:4] != MODE_SPLIT && run1 && en1) begin
                    a = count_once(timer1, mode_q[5:4]);
                    timer1 = a.cnt;
                    if (a.wrap) ovf1 = 1'b1;
                end
            end
            OP_WR_COUNT: begin
                case (it.reg_sel)
                    SEL_LOW0:  timer0.lo = it.wr_data;
                    SEL_HIGH0: timer0.hi = it.wr_data;
                    SEL_LOW1:  timer1.lo = it.wr_data;
                    default:   timer1.hi = it.wr_data;
                endcase
            end
            OP_WR_CTRL: begin
                run0 = it.wr_data[CTRL_RUN0];
                ovf0 = it.wr_data[CTRL_FLAG0];
                run1 = it.wr_data[CTRL_RUN1];
                ovf1 = it.wr_data[CTRL_FLAG1];
            end
            default: ;
        endcase
        r.low0  = timer0.lo;
        r.high0 = timer0.hi;
        r.low1  = timer1.lo;
        r.high1 = timer1.hi;
        r.flag0 = ovf0;
        r.flag1 = ovf1;
        return r;
    endfunction

    function automatic void check_field(input string field, input logic [7:0] exp_v,
                                        input logic [7:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0h, actual %0h", field, exp_v, got_v);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            timer0 = '0;
            timer1 = '0;
            ovf0   = 1'b0;
            ovf1   = 1'b0;
            run0   = 1'b0;
            run1   = 1'b0;
            mode_q = 8'd0;
            count_snapshots_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) mode_q = i_cfg_data;
            // Results are checked before the item of this edge is predicted.
            if (i_res_valid && !i_res_stall) begin
                if (count_snapshots_q.size() == 0) begin
                    $error("result item arrived with no expected result waiting");
                    fails++;
                end else begin
                    want = count_snapshots_q.pop_front();
                    check_field("low0_out", want.low0, i_low0);
                    check_field("high0_out", want.high0, i_high0);
                    check_field("low1_out", want.low1, i_low1);
                    check_field("high1_out", want.high1, i_high1);
                    check_field("flag0_out", {7'd0, want.flag0}, {7'd0, i_flag0});
                    check_field("flag1_out", {7'd0, want.flag1}, {7'd0, i_flag1});
                end
            end
            if (i_item_valid && !i_item_stall) begin
                item.op         = i_op;
                item.reg_sel    = i_reg_sel;
                item.wr_data    = i_wr_data;
                item.t0_fall    = i_t0_fall;
                item.t1_fall    = i_t1_fall;
                item.int0_level = i_int0_level;
                item.int1_level = i_int1_level;
                count_snapshots_q.push_back(next_counts(item));
            end
        end
        o_pending <= count_snapshots_q.size();
    end

endmodule

/* tb/sv/dual_timer_counter_four_modes_unit_tb.sv */
// ---------------------------------------------------------------------------
// Testbench for the dual timer/counter unit
// Drives directed and random items through all four modes with random idling
// on both channels; a separate checker predicts and compares every result.
// ---------------------------------------------------------------------------
module dual_timer_counter_four_modes_unit_tb;
    import dtc_pkg::*;

    // The fourth operation code is unused by the block; it must change nothing.
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 200;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 95;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [1:0] i_op = OP_TICK;
    logic [1:0] i_reg_sel = SEL_LOW0;
    logic [7:0] i_wr_data = 8'd0;
    logic       i_t0_fall = 1'b0;
    logic       i_t1_fall = 1'b0;
    logic       i_int0_level = 1'b0;
    logic       i_int1_level = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_low0_out;
    logic [7:0] o_high0_out;
    logic [7:0] o_low1_out;
    logic [7:0] o_high1_out;
    logic       o_flag0_out;
    logic       o_flag1_out;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data = 8'd0;

    int fail_count;
    int pending;
    int cycle_count = 0;

    // Idle probabilities in percent for each side, and the request for one long
    // hold-off of the receiver. The stimulus process sets them per phase.
    int send_gap_pct = 0;
    int stall_pct = 0;
    bit long_hold_req = 1'b0;

    dual_timer_counter_four_modes_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_reg_sel    (i_reg_sel),
        .i_wr_data    (i_wr_data),
        .i_t0_fall    (i_t0_fall),
        .i_t1_fall    (i_t1_fall),
        .i_int0_level (i_int0_level),
        .i_int1_level (i_int1_level),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_low0_out   (o_low0_out),
        .o_high0_out  (o_high0_out),
        .o_low1_out   (o_low1_out),
        .o_high1_out  (o_high1_out),
        .o_flag0_out  (o_flag0_out),
        .o_flag1_out  (o_flag1_out),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    dtc_count_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_valid),
        .i_item_stall (o_stall),
        .i_op         (i_op),
        .i_reg_sel    (i_reg_sel),
        .i_wr_data    (i_wr_data),
        .i_t0_fall    (i_t0_fall),
        .i_t1_fall    (i_t1_fall),
        .i_int0_level (i_int0_level),
        .i_int1_level (i_int1_level),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_low0       (o_low0_out),
        .i_high0      (o_high0_out),
        .i_low1       (o_low1_out),
        .i_high1      (o_high1_out),
        .i_flag0      (o_flag0_out),
        .i_flag1      (o_flag1_out),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Free-running clock with a period of 10 time units.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Random idle stretch length; one draw in twenty gives a long stretch.
    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic t_item make_item(input logic [1:0] op, input logic [1:0] sel,
                                        input logic [7:0] data, input logic [3:0] pins);
        t_item it;
        it.op         = op;
        it.reg_sel    = sel;
        it.wr_data    = data;
        it.t0_fall    = pins[3];
        it.t1_fall    = pins[2];
        it.int0_level = pins[1];
        it.int1_level = pins[0];
        return it;
    endfunction

    // Random item: mostly ticks with random pin samples. Count writes favor
    // values close to a wrap so that overflows come often, and control writes
    // mostly keep both timers running so the ticks have something to do.
    function automatic t_item random_item();
        t_item      it;
        int         pick;
        logic [7:0] data;
        pick = $urandom_range(0, 99);
        data = 8'($urandom_range(0, 255));
        if (pick < 70) begin
            it = make_item(OP_TICK, 2'($urandom_range(0, 3)), data,
                           4'($urandom_range(0, 15)));
        end else if (pick < 82) begin
            if ($urandom_range(0, 1) == 1) begin
                data = $urandom_range(0, 1) ? 8'($urandom_range(240, 255))
                                            : 8'($urandom_range(24, 31));
            end
            it = make_item(OP_WR_COUNT, 2'($urandom_range(0, 3)), data,
                           4'($urandom_range(0, 15)));
        end else if (pick < 95) begin
            if ($urandom_range(0, 99) < 85) begin
                data[CTRL_RUN0] = 1'b1;
                data[CTRL_RUN1] = 1'b1;
            end
            it = make_item(OP_WR_CTRL, 2'($urandom_range(0, 3)), data,
                           4'($urandom_range(0, 15)));
        end else begin
            it = make_item(OP_NONE, 2'($urandom_range(0, 3)), data,
                           4'($urandom_range(0, 15)));
        end
        return it;
    endfunction

    // Offers one item and returns at the edge where it is accepted. Valid stays
    // high into the next item unless a gap is inserted first.
    task automatic send_item(input t_item it);
        if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
            i_valid <= 1'b0;
            repeat (pick_gap()) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_op         <= it.op;
        i_reg_sel    <= it.reg_sel;
        i_wr_data    <= it.wr_data;
        i_t0_fall    <= it.t0_fall;
        i_t1_fall    <= it.t1_fall;
        i_int0_level <= it.int0_level;
        i_int1_level <= it.int1_level;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Stops offering items and waits until every expected result has arrived.
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // The mode register may only change while nothing is in flight.
    task automatic write_mode(input logic [7:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Receiver: random stalls of the result channel, plus one long hold-off on
    // request, counted here so that the sender keeps pushing meanwhile.
    initial begin
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 1'b0;
                i_stall <= 1'b0;
            end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                i_stall <= 1'b1;
                repeat (pick_gap()) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        logic [7:0] mode_val;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, mode 0 on both timers (the reset value). A tick with
        // both timers stopped must change nothing.
        send_item(make_item(OP_TICK, SEL_LOW0, 8'h00, 4'b1111));
        send_item(make_item(OP_WR_CTRL, SEL_LOW0, 8'h50, 4'b0000));
        // Low bytes at the prescale top, low1's upper bits set: 13-bit count must
        // clear them, and both high bytes at their maximum must overflow.
        send_item(make_item(OP_WR_COUNT, SEL_LOW0, 8'h1f, 4'b0000));
        send_item(make_item(OP_WR_COUNT, SEL_HIGH0, 8'hff, 4'b0000));
        send_item(make_item(OP_WR_COUNT, SEL_LOW1, 8'hff, 4'b0000));
        send_item(make_item(OP_WR_COUNT, SEL_HIGH1, 8'hff, 4'b0000));
        send_item(make_item(OP_TICK, SEL_LOW0, 8'h00, 4'b0000));
        // The flags are set by an overflow, never toggled by a later tick.
        send_item(make_item(OP_TICK, SEL_HIGH1, 8'hff, 4'b0000));
        send_item(make_item(OP_WR_CTRL, SEL_HIGH1, 8'hf0, 4'b1111));
        send_item(make_item(OP_WR_CTRL, SEL_LOW0, 8'h0f, 4'b0000));
        // The unused operation code reports the state and leaves it alone.
        send_item(make_item(OP_NONE, SEL_HIGH1, 8'hff, 4'b1111));

        // 16-bit count on both timers: a wrap from all ones sets the flag.
        write_mode({2'b00, MODE_16BIT, 2'b00, MODE_16BIT});
        send_item(make_item(OP_WR_CTRL, SEL_LOW0, 8'h50, 4'b0000));
        send_item(make_item(OP_WR_COUNT, SEL_LOW0, 8'hff, 4'b0000));
        send_item(make_item(OP_WR_COUNT, SEL_HIGH0, 8'hff, 4'b0000));
        send_item(make_item(OP_TICK, SEL_LOW0, 8'h00, 4'b0000));

        // Auto-reload: the low byte reloads from the high byte, which stays put.
        write_mode({2'b00, MODE_RELOAD, 2'b00, MODE_RELOAD});
        send_item(make_item(OP_WR_COUNT, SEL_LOW0, 8'hff, 4'b0000));
        send_item(make_item(OP_WR_COUNT, SEL_HIGH0, 8'h80, 4'b0000));
        send_item(make_item(OP_TICK, SEL_LOW0, 8'h00, 4'b0000));

        // Timer 0 split, timer 1 in mode 0: the high byte of timer 0 runs on
        // run1 and sets flag 1, while timer 1 runs without its run bit.
        write_mode({2'b00, MODE_13BIT, 2'b00, MODE_SPLIT});
        send_item(make_item(OP_WR_CTRL, SEL_LOW0, 8'h40, 4'b0000));
        send_item(make_item(OP_WR_COUNT, SEL_HIGH0, 8'hff, 4'b0000));
        send_item(make_item(OP_TICK, SEL_LOW0, 8'h00, 4'b0000));

        // Both timers in mode 3: timer 1 holds its count.
        write_mode({2'b00, MODE_SPLIT, 2'b00, MODE_SPLIT});
        send_item(make_item(OP_WR_CTRL, SEL_LOW0, 8'h50, 4'b0000));
        send_item(make_item(OP_TICK, SEL_LOW0, 8'h00, 4'b0000));

        // Random part. Each phase runs under its own mode: all ones and all
        // zeros first, then random modes. Every third phase has no idling at
        // all; the others idle both sides at random.
        for (int p = 0; p < PHASES; p++) begin
            if (p == 0) begin
                mode_val = 8'hff;
            end else if (p == 1) begin
                mode_val = 8'h00;
            end else begin
                mode_val = 8'($urandom_range(0, 255));
            end
            write_mode(mode_val);
            if (p % 3 == 0) begin
                send_gap_pct = 0;
                stall_pct    = 0;
            end else begin
                send_gap_pct = 30;
                stall_pct    = 30;
            end
            // One phase opens with a long hold-off of the receiver while items
            // keep coming back to back, so the block fills and stalls its input.
            if (p == 2) begin
                send_gap_pct  = 0;
                long_hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 2 && n == 30) send_gap_pct = 30;
                send_item(random_item());
            end
        end

        // Wait for the last results, then keep the clock running so that a
        // stray extra result would still be caught.
        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/dtc_pkg.sv
rtl/dtc_advance.sv
rtl/dtc_update.sv
rtl/dual_timer_counter_four_modes_unit.sv
rtl/dtc_checker.sv
tb/sv/dtc_count_checker.sv
tb/sv/dual_timer_counter_four_modes_unit_tb.sv
